@@ hw/rtl/swc_pkg.sv @@
`default_nettype none
package swc_pkg;

	localparam int MAX_COLUMNS = 64;
	localparam int MAX_ROWS    = 64;
	localparam int RANDOM_BITS = 16;
	localparam int SITE_COUNT  = MAX_COLUMNS * MAX_ROWS;

	localparam int SITE_W = $clog2(SITE_COUNT);
	localparam int CNT_W  = SITE_W + 1;
	localparam int COL_W  = $clog2(MAX_COLUMNS);
	localparam int ROW_W  = $clog2(MAX_ROWS);
	localparam int SIZE_W = 7;
	localparam int THR_W  = 17;
	localparam int CFG_W  = 17;
	localparam int IDX_W  = 2;
	localparam int QUE_W  = ROW_W + COL_W + SITE_W;

	localparam logic [SIZE_W-1:0] SIZE_MIN  = SIZE_W'(2);
	localparam logic [SIZE_W-1:0] COLS_MAX  = SIZE_W'(MAX_COLUMNS);
	localparam logic [SIZE_W-1:0] ROWS_MAX  = SIZE_W'(MAX_ROWS);
	localparam logic [THR_W-1:0]  THR_RESET = THR_W'(32768);
	localparam logic [RANDOM_BITS-1:0] HALF_FRACTION = RANDOM_BITS'(1) << (RANDOM_BITS - 1);

	typedef enum logic [IDX_W-1:0] {
		REG_SIZE_X = 2'd0,
		REG_SIZE_Y = 2'd1,
		REG_FREEZE = 2'd2,
		REG_NONE   = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_WRITE_SITE = 2'd0,
		OP_WRITE_RAND = 2'd1,
		OP_SWEEP      = 2'd2,
		OP_READ_SPIN  = 2'd3
	} op_t;

	typedef struct packed {
		logic [SIZE_W-1:0] size_x;
		logic [SIZE_W-1:0] size_y;
		logic [THR_W-1:0]  freeze;
		logic [CNT_W-1:0]  sites;
	} cfg_t;

endpackage
`default_nettype wire

@@ hw/rtl/swc_ram.sv @@
`default_nettype none
module swc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

@@ hw/rtl/swc_cfg.sv @@
`default_nettype none
module swc_cfg (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [swc_pkg::IDX_W-1:0]  cfg_index,
	input  wire logic [swc_pkg::CFG_W-1:0]  cfg_data,
	output swc_pkg::cfg_t                   cfg
);
	import swc_pkg::*;

	logic [SIZE_W-1:0] size_x_q, size_y_q, wr_size;
	logic [THR_W-1:0]  freeze_q;
	logic [2*SIZE_W-1:0] prod;

	assign wr_size = cfg_data[SIZE_W-1:0];
	assign prod    = size_x_q * size_y_q;

	// hold clamped size registers and the freeze threshold; site count follows the sizes directly
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= COLS_MAX;
			size_y_q <= ROWS_MAX;
			freeze_q <= THR_RESET;
		end else begin
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_index))
					REG_SIZE_X: size_x_q <= (wr_size < SIZE_MIN) ? SIZE_MIN :
						(wr_size > COLS_MAX) ? COLS_MAX : wr_size;
					REG_SIZE_Y: size_y_q <= (wr_size < SIZE_MIN) ? SIZE_MIN :
						(wr_size > ROWS_MAX) ? ROWS_MAX : wr_size;
					REG_FREEZE: freeze_q <= cfg_data[THR_W-1:0];
					default: ;
				endcase
			end
		end
	end

	assign cfg.size_x = size_x_q;
	assign cfg.size_y = size_y_q;
	assign cfg.freeze = freeze_q;
	assign cfg.sites  = prod[CNT_W-1:0];

endmodule
`default_nettype wire

@@ hw/rtl/swendsen_wang_cluster_sweep.sv @@
`default_nettype none
// Channel | Handshake          | Payload
// in      | in_valid, in_stall | op, site_index, spin_in, rand_horizontal/vertical/flip
// out     | out_valid, out_stall | spin_out, clusters_found, status
// cfg     | cfg_we             | cfg_index, cfg_data
// A site write is done on acceptance, a spin read passes through S_READ. A sweep clears
// the visited map over size_x*size_y sites, reads and checks each seed site, closes each
// cluster, posts the result, and per cluster member reads the queue, reads and checks
// the centre, then reads and checks the four neighbours in turn through the single read
// port of each store.
// After reset a clearing pass over all 4096 sites zeroes the spin and visited
// stores; no item is taken meanwhile. in_stall is high while work runs or a
// result waits for a stalled out channel.
module swendsen_wang_cluster_sweep (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [1:0]                        op,
	input  wire logic [swc_pkg::SITE_W-1:0]        site_index,
	input  wire logic                              spin_in,
	input  wire logic [swc_pkg::RANDOM_BITS-1:0]   rand_horizontal,
	input  wire logic [swc_pkg::RANDOM_BITS-1:0]   rand_vertical,
	input  wire logic [swc_pkg::RANDOM_BITS-1:0]   rand_flip,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   spin_out,
	output logic [12:0]                            clusters_found,
	output logic                                   status,
	input  wire logic                              cfg_we,
	input  wire logic [swc_pkg::IDX_W-1:0]         cfg_index,
	input  wire logic [swc_pkg::CFG_W-1:0]         cfg_data
);
	import swc_pkg::*;

	typedef enum logic [3:0] {
		S_CLR_ALL, S_IDLE, S_READ, S_CLR_VIS, S_SEED_RD, S_SEED_CHK,
		S_Q_RD, S_P_RD, S_P_GOT, S_N_RD, S_N_CHK, S_DONE
	} state_t;

	typedef enum logic [1:0] {
		NB_RIGHT = 2'd0, NB_DOWN = 2'd1, NB_LEFT = 2'd2, NB_UP = 2'd3
	} nb_t;

	cfg_t cfg;

	state_t state_q;
	nb_t    nb_dir_q;
	logic [SITE_W-1:0] cnt_q, seed_q, p_q, nb_q;
	logic [ROW_W-1:0]  sr_q, pr_q, nr_q;
	logic [COL_W-1:0]  sc_q, pc_q, nc_q;
	logic [CNT_W-1:0]  head_q, tail_q;
	logic [12:0]       clusters_q;
	logic              flip_q, s_q, hb_q, vb_q;
	logic              out_valid_q, spin_out_q, status_q;
	logic [12:0]       clusters_out_q;

	logic accept, in_range, out_take, seed_last, nb_join;
	logic [SITE_W-1:0] nb_lin;
	logic [ROW_W-1:0]  nb_r;
	logic [COL_W-1:0]  nb_c;
	logic [SITE_W-1:0] qp;
	logic [ROW_W-1:0]  qr;
	logic [COL_W-1:0]  qc;
	logic bond;
	logic col_last, row_last, seed_col_last;

	// memory ports
	logic              spin_we, spin_wd, spin_rd;
	logic [SITE_W-1:0] spin_wa, spin_ra;
	logic              vis_we, vis_wd, vis_rd;
	logic [SITE_W-1:0] vis_wa, vis_ra;
	logic              rnd_we;
	logic [SITE_W-1:0] rnd_ra;
	logic [RANDOM_BITS-1:0] h_rd, v_rd;
	logic              flip_rd;
	logic              q_we;
	logic [SITE_W-1:0] q_wa;
	logic [QUE_W-1:0]  q_wd, q_rd;

	swc_cfg u_cfg (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .cfg
	);

	assign out_take = out_valid_q && !out_stall;
	assign in_stall = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;
	assign in_range = {1'b0, site_index} < cfg.sites;
	assign seed_last = {1'b0, seed_q} == cfg.sites - CNT_W'(1);
	assign seed_col_last = {1'b0, sc_q} == cfg.size_x - SIZE_W'(1);

	assign qp = q_rd[SITE_W-1:0];
	assign qc = q_rd[SITE_W +: COL_W];
	assign qr = q_rd[SITE_W+COL_W +: ROW_W];

	// neighbour of the current member in periodic geometry
	assign col_last = {1'b0, pc_q} == cfg.size_x - SIZE_W'(1);
	assign row_last = {1'b0, pr_q} == cfg.size_y - SIZE_W'(1);
	always_comb begin
		nb_r   = pr_q;
		nb_c   = pc_q;
		nb_lin = p_q;
		unique case (nb_dir_q)
			NB_RIGHT: begin
				nb_c   = col_last ? '0 : pc_q + COL_W'(1);
				nb_lin = col_last ? SITE_W'({1'b0, p_q} - CNT_W'(cfg.size_x) + CNT_W'(1))
					: p_q + SITE_W'(1);
			end
			NB_DOWN: begin
				nb_r   = row_last ? '0 : pr_q + ROW_W'(1);
				nb_lin = row_last ? SITE_W'(pc_q) : SITE_W'({1'b0, p_q} + CNT_W'(cfg.size_x));
			end
			NB_LEFT: begin
				nb_c   = (pc_q == '0) ? COL_W'(cfg.size_x - SIZE_W'(1)) : pc_q - COL_W'(1);
				nb_lin = (pc_q == '0) ? SITE_W'({1'b0, p_q} + CNT_W'(cfg.size_x) - CNT_W'(1))
					: p_q - SITE_W'(1);
			end
			NB_UP: begin
				nb_r   = (pr_q == '0) ? ROW_W'(cfg.size_y - SIZE_W'(1)) : pr_q - ROW_W'(1);
				nb_lin = (pr_q == '0) ?
					SITE_W'({1'b0, p_q} + cfg.sites - CNT_W'(cfg.size_x))
					: SITE_W'({1'b0, p_q} - CNT_W'(cfg.size_x));
			end
			default: ;
		endcase
	end

	// bond towards the neighbour under check
	always_comb begin
		unique case (nb_dir_q)
			NB_RIGHT: bond = hb_q;
			NB_DOWN:  bond = vb_q;
			NB_LEFT:  bond = {1'b0, h_rd} < cfg.freeze;
			NB_UP:    bond = {1'b0, v_rd} < cfg.freeze;
			default:  bond = 1'b0;
		endcase
	end
	assign nb_join = (state_q == S_N_CHK) && bond && !vis_rd && (spin_rd == s_q)
		&& (tail_q < CNT_W'(SITE_COUNT));

	// memory port steering
	always_comb begin
		spin_we = 1'b0;
		spin_wa = site_index;
		spin_wd = spin_in;
		vis_we  = 1'b0;
		vis_wa  = cnt_q;
		vis_wd  = 1'b0;
		q_we    = 1'b0;
		q_wa    = tail_q[SITE_W-1:0];
		q_wd    = {nr_q, nc_q, nb_q};
		rnd_we  = accept && in_range && (op_t'(op) == OP_WRITE_SITE || op_t'(op) == OP_WRITE_RAND);
		unique case (state_q)
			S_CLR_ALL: begin
				spin_we = 1'b1;
				spin_wa = cnt_q;
				spin_wd = 1'b0;
				vis_we  = 1'b1;
			end
			S_CLR_VIS: vis_we = 1'b1;
			S_IDLE: spin_we = accept && in_range && op_t'(op) == OP_WRITE_SITE;
			S_SEED_CHK: begin
				vis_we = !vis_rd;
				vis_wa = seed_q;
				vis_wd = 1'b1;
				q_we   = !vis_rd;
				q_wa   = '0;
				q_wd   = {sr_q, sc_q, seed_q};
			end
			S_P_GOT: begin
				spin_we = flip_q;
				spin_wa = p_q;
				spin_wd = !spin_rd;
			end
			S_N_CHK: begin
				vis_we = nb_join;
				vis_wa = nb_q;
				vis_wd = 1'b1;
				q_we   = nb_join;
			end
			default: ;
		endcase
		unique case (state_q)
			S_P_RD: spin_ra = qp;
			S_N_RD: spin_ra = nb_lin;
			default: spin_ra = site_index;
		endcase
		vis_ra = (state_q == S_N_RD) ? nb_lin : seed_q;
		rnd_ra = (state_q == S_P_RD) ? qp : nb_lin;
	end

	swc_ram #(.WIDTH(1), .DEPTH(SITE_COUNT)) u_spin (
		.clk, .we(spin_we), .waddr(spin_wa), .wdata(spin_wd), .raddr(spin_ra), .rdata(spin_rd)
	);
	swc_ram #(.WIDTH(1), .DEPTH(SITE_COUNT)) u_visited (
		.clk, .we(vis_we), .waddr(vis_wa), .wdata(vis_wd), .raddr(vis_ra), .rdata(vis_rd)
	);
	swc_ram #(.WIDTH(RANDOM_BITS), .DEPTH(SITE_COUNT)) u_rand_h (
		.clk, .we(rnd_we), .waddr(site_index), .wdata(rand_horizontal),
		.raddr(rnd_ra), .rdata(h_rd)
	);
	swc_ram #(.WIDTH(RANDOM_BITS), .DEPTH(SITE_COUNT)) u_rand_v (
		.clk, .we(rnd_we), .waddr(site_index), .wdata(rand_vertical),
		.raddr(rnd_ra), .rdata(v_rd)
	);
	swc_ram #(.WIDTH(1), .DEPTH(SITE_COUNT)) u_flip (
		.clk, .we(rnd_we), .waddr(site_index), .wdata(rand_flip < HALF_FRACTION),
		.raddr(seed_q), .rdata(flip_rd)
	);
	swc_ram #(.WIDTH(QUE_W), .DEPTH(SITE_COUNT)) u_queue (
		.clk, .we(q_we), .waddr(q_wa), .wdata(q_wd),
		.raddr(head_q[SITE_W-1:0]), .rdata(q_rd)
	);

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLR_ALL;
			nb_dir_q       <= NB_RIGHT;
			cnt_q          <= '0;
			seed_q         <= '0;
			sr_q           <= '0;
			sc_q           <= '0;
			head_q         <= '0;
			tail_q         <= '0;
			clusters_q     <= '0;
			out_valid_q    <= 1'b0;
			spin_out_q     <= 1'b0;
			status_q       <= 1'b0;
			clusters_out_q <= '0;
			flip_q         <= 1'b0;
			s_q            <= 1'b0;
			hb_q           <= 1'b0;
			vb_q           <= 1'b0;
			p_q            <= '0;
			pr_q           <= '0;
			pc_q           <= '0;
			nb_q           <= '0;
			nr_q           <= '0;
			nc_q           <= '0;
		end else begin
			if (out_take) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR_ALL: begin
					cnt_q <= cnt_q + SITE_W'(1);
					if (cnt_q == SITE_W'(SITE_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						spin_out_q     <= 1'b0;
						clusters_out_q <= '0;
						status_q       <= 1'b0;
						if (op_t'(op) == OP_SWEEP) begin
							cnt_q   <= '0;
							state_q <= S_CLR_VIS;
						end else if (!in_range) begin
							status_q    <= 1'b1;
							out_valid_q <= 1'b1;
						end else if (op_t'(op) == OP_READ_SPIN) begin
							state_q <= S_READ;
						end else begin
							out_valid_q <= 1'b1;
						end
					end
				end
				S_READ: begin
					spin_out_q  <= spin_rd;
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_CLR_VIS: begin
					cnt_q <= cnt_q + SITE_W'(1);
					if ({1'b0, cnt_q} == cfg.sites - CNT_W'(1)) begin
						seed_q     <= '0;
						sr_q       <= '0;
						sc_q       <= '0;
						clusters_q <= '0;
						state_q    <= S_SEED_RD;
					end
				end
				S_SEED_RD: state_q <= S_SEED_CHK;
				S_SEED_CHK: begin
					if (vis_rd) begin
						if (seed_last) begin
							state_q <= S_DONE;
						end else begin
							seed_q  <= seed_q + SITE_W'(1);
							sc_q    <= seed_col_last ? '0 : sc_q + COL_W'(1);
							sr_q    <= seed_col_last ? sr_q + ROW_W'(1) : sr_q;
							state_q <= S_SEED_RD;
						end
					end else begin
						clusters_q <= clusters_q + 13'd1;
						flip_q     <= flip_rd;
						head_q     <= '0;
						tail_q     <= CNT_W'(1);
						state_q    <= S_Q_RD;
					end
				end
				S_Q_RD: begin
					if (head_q == tail_q) begin
						if (seed_last) begin
							state_q <= S_DONE;
						end else begin
							seed_q  <= seed_q + SITE_W'(1);
							sc_q    <= seed_col_last ? '0 : sc_q + COL_W'(1);
							sr_q    <= seed_col_last ? sr_q + ROW_W'(1) : sr_q;
							state_q <= S_SEED_RD;
						end
					end else begin
						head_q  <= head_q + CNT_W'(1);
						state_q <= S_P_RD;
					end
				end
				S_P_RD: begin
					p_q     <= qp;
					pr_q    <= qr;
					pc_q    <= qc;
					state_q <= S_P_GOT;
				end
				S_P_GOT: begin
					s_q      <= spin_rd;
					hb_q     <= {1'b0, h_rd} < cfg.freeze;
					vb_q     <= {1'b0, v_rd} < cfg.freeze;
					nb_dir_q <= NB_RIGHT;
					state_q  <= S_N_RD;
				end
				S_N_RD: begin
					nb_q    <= nb_lin;
					nr_q    <= nb_r;
					nc_q    <= nb_c;
					state_q <= S_N_CHK;
				end
				S_N_CHK: begin
					if (nb_join) begin
						tail_q <= tail_q + CNT_W'(1);
					end
					if (nb_dir_q == NB_UP) begin
						state_q <= S_Q_RD;
					end else begin
						nb_dir_q <= nb_t'(nb_dir_q + 2'd1);
						state_q  <= S_N_RD;
					end
				end
				S_DONE: begin
					clusters_out_q <= clusters_q;
					out_valid_q    <= 1'b1;
					state_q        <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign spin_out       = spin_out_q;
	assign clusters_found = clusters_out_q;
	assign status         = status_q;

endmodule
`default_nettype wire

@@ tb/tb.sv @@
module tb;
	import swc_pkg::*;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [1:0]               op = OP_READ_SPIN;
	logic [SITE_W-1:0]        site_index = '0;
	logic                     spin_in = 1'b0;
	logic [RANDOM_BITS-1:0]   rand_horizontal = '0;
	logic [RANDOM_BITS-1:0]   rand_vertical = '0;
	logic [RANDOM_BITS-1:0]   rand_flip = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic                     spin_out;
	logic [12:0]              clusters_found;
	logic                     status;
	logic                     cfg_we = 1'b0;
	logic [IDX_W-1:0]         cfg_index = REG_NONE;
	logic [CFG_W-1:0]         cfg_data = '0;

	typedef struct {
		bit        spin;
		bit [12:0] clusters;
		bit        status;
	} site_result_t;

	// lattice copy used for prediction
	bit        lat_spin [SITE_COUNT];
	bit [15:0] lat_rh   [SITE_COUNT];
	bit [15:0] lat_rv   [SITE_COUNT];
	bit        lat_flip [SITE_COUNT];
	int        cur_x = 64, cur_y = 64;
	bit [16:0] cur_thr = 17'd32768;

	site_result_t pending_results[$];
	int  error_count = 0;
	int  transfers_in = 0, sweeps_done = 0, results_seen = 0;
	bit  quiet = 1'b0;
	int  hold_left = 0, burst_left = 0;
	int  idle_cycles = 0;

	swendsen_wang_cluster_sweep dut (.*);

	always #2 clk = ~clk;

	// breadth-first cluster build over the stored lattice
	function automatic int run_cluster_sweep();
		bit visited [SITE_COUNT];
		int members [SITE_COUNT];
		int n, found, head, tail, p, r, c, nb, k;
		bit s;
		bit bonded, flip;
		n = cur_x * cur_y;
		found = 0;
		foreach (visited[i]) visited[i] = 1'b0;
		for (int seed = 0; seed < n; seed++) begin
			if (visited[seed]) continue;
			found++;
			flip = lat_flip[seed];
			visited[seed] = 1'b1;
			members[0] = seed;
			head = 0;
			tail = 1;
			while (head < tail) begin
				p = members[head++];
				r = p / cur_x;
				c = p % cur_x;
				s = lat_spin[p];
				// right, down, left, up in that order
				for (k = 0; k < 4; k++) begin
					case (k)
						0: begin
							nb = r * cur_x + (c + 1) % cur_x;
							bonded = lat_rh[p] < cur_thr;
						end
						1: begin
							nb = ((r + 1) % cur_y) * cur_x + c;
							bonded = lat_rv[p] < cur_thr;
						end
						2: begin
							nb = r * cur_x + (c + cur_x - 1) % cur_x;
							bonded = lat_rh[nb] < cur_thr;
						end
						default: begin
							nb = ((r + cur_y - 1) % cur_y) * cur_x + c;
							bonded = lat_rv[nb] < cur_thr;
						end
					endcase
					if (bonded && !visited[nb] && lat_spin[nb] == s) begin
						visited[nb] = 1'b1;
						members[tail++] = nb;
					end
				end
				if (flip) lat_spin[p] = ~lat_spin[p];
			end
		end
		return found;
	endfunction

	function automatic site_result_t predict_result(op_t o, int site, bit sp,
			bit [15:0] rh, bit [15:0] rv, bit [15:0] rf);
		site_result_t res;
		int c;
		res = '{spin: 1'b0, clusters: 13'd0, status: 1'b0};
		if (o == OP_SWEEP) begin
			c = run_cluster_sweep();
			res.clusters = (c > 8191) ? 13'd8191 : 13'(c);
		end else if (site >= cur_x * cur_y) begin
			res.status = 1'b1;
		end else if (o == OP_READ_SPIN) begin
			res.spin = lat_spin[site];
		end else begin
			if (o == OP_WRITE_SITE) lat_spin[site] = sp;
			lat_rh[site] = rh;
			lat_rv[site] = rv;
			lat_flip[site] = rf < 16'd32768;
		end
		return res;
	endfunction

	// predict on each input transfer, check each output transfer
	always @(negedge clk) begin
		site_result_t exp_r;
		if (arst_n && in_valid && !in_stall) begin
			transfers_in++;
			if (op == OP_SWEEP) sweeps_done++;
			pending_results.insert(pending_results.size(),
				predict_result(op_t'(op), site_index, spin_in,
				rand_horizontal, rand_vertical, rand_flip));
		end
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$display("%0t: result with nothing expected: spin %0b clusters %0d status %0b",
					$time, spin_out, clusters_found, status);
				error_count++;
			end else begin
				exp_r = pending_results[0];
				pending_results.delete(0);
				if (spin_out !== exp_r.spin) begin
					$display("%0t: spin_out expected %0b actual %0b", $time, exp_r.spin, spin_out);
					error_count++;
				end
				if (clusters_found !== exp_r.clusters) begin
					$display("%0t: clusters_found expected %0d actual %0d", $time,
						exp_r.clusters, clusters_found);
					error_count++;
				end
				if (status !== exp_r.status) begin
					$display("%0t: status expected %0b actual %0b", $time, exp_r.status, status);
					error_count++;
				end
			end
		end
	end

	// stall the result channel in bursts, or for a long hold on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (burst_left > 0) begin
			burst_left <= burst_left - 1;
			out_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			burst_left <= $urandom_range(0, 13);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// end the run when nothing moves for too long
	always @(negedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 60000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// offer one item and hold it until the transfer; called right after a rising edge
	task automatic send_item(op_t o, int site, bit sp, bit [15:0] rh, bit [15:0] rv,
			bit [15:0] rf);
		bit taken;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		site_index <= SITE_W'(site);
		spin_in <= sp;
		rand_horizontal <= rh;
		rand_vertical <= rv;
		rand_flip <= rf;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic send_random_write(int site);
		send_item(op_t'($urandom_range(0, 1)), site, 1'($urandom_range(0, 1)),
			16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	// drop valid and wait until every expected result is in
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, int value);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(value);
		case (idx)
			REG_SIZE_X: cur_x = (value & 'h7f) < 2 ? 2 : ((value & 'h7f) > 64 ? 64 : value & 'h7f);
			REG_SIZE_Y: cur_y = (value & 'h7f) < 2 ? 2 : ((value & 'h7f) > 64 ? 64 : value & 'h7f);
			REG_FREEZE: cur_thr = 17'(value);
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_lattice(int x, int y, int thr);
		write_reg(REG_SIZE_X, x);
		write_reg(REG_SIZE_Y, y);
		write_reg(REG_FREEZE, thr);
	endtask

	// fill the first 128 sites so every later sweep reads written randoms
	task automatic test_fill();
		for (int s = 0; s < 128; s++) begin
			case (s % 4)
				0: send_item(OP_WRITE_SITE, s, 1'b1, 16'hffff, 16'h0000, 16'd32767);
				1: send_item(OP_WRITE_SITE, s, 1'b0, 16'h0000, 16'hffff, 16'd32768);
				default: send_item(OP_WRITE_SITE, s, 1'($urandom_range(0, 1)), 16'($urandom),
					16'($urandom), 16'($urandom));
			endcase
		end
		send_item(OP_READ_SPIN, 4095, 1'b0, 16'h0, 16'h0, 16'h0);
		send_item(OP_WRITE_RAND, 4095, 1'b1, 16'hffff, 16'hffff, 16'hffff);
		send_item(OP_READ_SPIN, 0, 1'b0, 16'h0, 16'h0, 16'h0);
	endtask

	// clamping, out-of-range sites, two-wide lattices, threshold extremes
	task automatic test_directed();
		set_lattice(0, 1, 65536);
		send_item(OP_WRITE_SITE, 4, 1'b1, 16'h1234, 16'h4321, 16'h0);
		send_item(OP_WRITE_RAND, 4095, 1'b0, 16'h0, 16'h0, 16'h0);
		send_item(OP_READ_SPIN, 4, 1'b0, 16'h0, 16'h0, 16'h0);
		send_item(OP_SWEEP, 0, 1'b0, 16'h0, 16'h0, 16'h0);
		write_reg(REG_FREEZE, 0);
		send_item(OP_SWEEP, 0, 1'b0, 16'h0, 16'h0, 16'h0);
		send_item(OP_READ_SPIN, 3, 1'b0, 16'h0, 16'h0, 16'h0);
		set_lattice(127, 2, 131071);
		send_item(OP_SWEEP, 0, 1'b0, 16'h0, 16'h0, 16'h0);
		send_item(OP_READ_SPIN, 127, 1'b0, 16'h0, 16'h0, 16'h0);
		send_item(OP_READ_SPIN, 128, 1'b0, 16'h0, 16'h0, 16'h0);
		set_lattice(2, 64, 32768);
		send_item(OP_SWEEP, 0, 1'b0, 16'h0, 16'h0, 16'h0);
		write_reg(REG_NONE, 5);
		send_item(OP_SWEEP, 0, 1'b0, 16'h0, 16'h0, 16'h0);
	endtask

	// random lattices of at most 128 sites, mostly site traffic with sweeps between
	task automatic test_random(int count, bit calm);
		int x, y, n, roll;
		for (int i = 0; i < count; i++) begin
			if (i % 90 == 0) begin
				x = $urandom_range(2, 16);
				y = $urandom_range(2, 128 / x > 64 ? 64 : 128 / x);
				set_lattice(x, y, $urandom_range(0, 3) == 0 ? $urandom_range(0, 131071)
					: $urandom_range(16384, 49152));
				quiet = calm || ($urandom_range(0, 3) == 0);
			end
			n = cur_x * cur_y;
			roll = $urandom_range(0, 99);
			if (roll < 5) send_item(OP_SWEEP, $urandom_range(0, 4095), 1'($urandom_range(0, 1)),
				16'($urandom), 16'($urandom), 16'($urandom));
			else if (roll < 12) send_item(op_t'($urandom_range(0, 3) == 2 ? 3 : $urandom_range(0, 3)),
				$urandom_range(n, 4095), 1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
				16'($urandom));
			else if (roll < 40) send_item(OP_READ_SPIN, $urandom_range(0, n - 1), 1'b0,
				16'($urandom), 16'($urandom), 16'($urandom));
			else send_random_write($urandom_range(0, n - 1));
		end
		quiet = calm;
	endtask

	// hold results back so the block backs up, then pause until all results are in
	task automatic test_backpressure();
		drain();
		hold_left = 400;
		for (int i = 0; i < 30; i++) send_item(OP_READ_SPIN, $urandom_range(0, 3), 1'b0,
			16'($urandom), 16'($urandom), 16'($urandom));
		send_item(OP_SWEEP, 0, 1'b0, 16'h0, 16'h0, 16'h0);
		drain();
		send_item(OP_SWEEP, 0, 1'b0, 16'h0, 16'h0, 16'h0);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill();
		test_directed();
		test_random(1150, 1'b0);
		test_backpressure();
		quiet = 1'b1;
		set_lattice(8, 8, 40000);
		test_random(40, 1'b1);
		drain();
		repeat (20) @(posedge clk);
		$display("Covered %0d items, %0d sweeps and %0d results over varied lattices,",
			transfers_in, sweeps_done, results_seen);
		$display("bond thresholds, out-of-range sites and stalls on both channels.");
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

@@ swendsen_wang_cluster_sweep.f @@
hw/rtl/swc_pkg.sv
hw/rtl/swc_ram.sv
hw/rtl/swc_cfg.sv
hw/rtl/swendsen_wang_cluster_sweep.sv
tb/tb.sv
